[sv/psched_pkg.sv]
// Shared types and constants for the preemptive priority scheduler.
// No dependencies.
`default_nettype none
package psched_pkg;
	localparam int TIME_W        = 16;
	localparam int BURST_W       = 12;
	localparam int PRIO_W        = 8;
	localparam int SLOT_W        = 4;
	localparam int MAX_TASKS_DEF = 16;

	typedef struct packed {
		logic [TIME_W-1:0]  arrival;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
		logic [BURST_W-1:0] remaining;
		logic [TIME_W-1:0]  start;
	} task_t;
endpackage
`default_nettype wire

[sv/psched_ram.sv]
// Task table: one write port, one read port with registered read data.
// Depends on psched_pkg.
`default_nettype none
module psched_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire psched_pkg::task_t wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output psched_pkg::task_t      rdata
);
	import psched_pkg::*;

	task_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[sv/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler top level: command port, scan sequencer, result registers.
// Depends on psched_pkg and psched_ram.
//
//  channel   handshake          payload
//  -------   ----------------   ---------------------------------------------
//  command   start / busy       action, slot, arrival, burst, prio
//  result    done (strobe)      ran_slot, idle, finished, response_time,
//                               completion_time, turnaround_time,
//                               waiting_time, all_done
//
// A load is written in its accept cycle and leaves busy low.
// A tick holds busy through ST_SCAN (one table read per slot), ST_LAST (compare of the
// last read), ST_WB (write-back of the chosen entry) and ST_OUT (result formation); done
// pulses in the cycle after. The single table read port sets the length of the scan.
// Reset clears the pending flags, pending count, time and sequencer; the table
// itself needs no clearing. Results cannot be stalled.
`default_nettype none
module preemptive_priority_scheduler #(
	parameter int MAX_TASKS = psched_pkg::MAX_TASKS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            action,
	input  wire logic [psched_pkg::SLOT_W-1:0]   slot,
	input  wire logic [psched_pkg::TIME_W-1:0]   arrival,
	input  wire logic [psched_pkg::BURST_W-1:0]  burst,
	input  wire logic [psched_pkg::PRIO_W-1:0]   prio,
	output logic                                 done,
	output logic [psched_pkg::SLOT_W-1:0]        ran_slot,
	output logic                                 idle,
	output logic                                 finished,
	output logic [psched_pkg::TIME_W-1:0]        response_time,
	output logic [psched_pkg::TIME_W-1:0]        completion_time,
	output logic [psched_pkg::TIME_W-1:0]        turnaround_time,
	output logic [psched_pkg::TIME_W-1:0]        waiting_time,
	output logic                                 all_done
);
	import psched_pkg::*;

	localparam int AW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(MAX_TASKS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_LAST = 3'd2;
	localparam logic [2:0] ST_WB   = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]           state_q;
	logic [AW-1:0]        idx_q;
	logic [AW-1:0]        idx_s1;
	logic                 valid_s1;
	logic                 pend_s1;
	logic [MAX_TASKS-1:0] pend_q;
	logic [CW-1:0]        cnt_q;
	logic [TIME_W-1:0]    now_q;

	logic                 found_q;
	logic [AW-1:0]        best_idx_q;
	task_t                best_q;
	logic                 fin_q;
	logic [TIME_W-1:0]    turn_q;

	task_t                rdata;
	task_t                wdata;
	logic [AW-1:0]        waddr;
	logic                 we;

	logic                 accept;
	logic                 load_ok;
	logic [AW-1:0]        load_addr;
	logic                 cand;
	logic                 better;
	logic [BURST_W-1:0]   rem_new;
	logic [TIME_W-1:0]    start_new;
	logic [TIME_W-1:0]    now_next;
	logic [TIME_W-1:0]    turn_d;
	logic [TIME_W-1:0]    burst_ext;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign load_ok   = accept && !action && (32'(slot) < MAX_TASKS);
	assign load_addr = AW'(slot);

	assign cand   = valid_s1 && pend_s1 && (rdata.arrival <= now_q);
	assign better = !found_q || (rdata.prio < best_q.prio) ||
		((rdata.prio == best_q.prio) && (rdata.arrival < best_q.arrival));

	assign rem_new   = best_q.remaining - BURST_W'(1);
	assign start_new = (best_q.remaining == best_q.burst) ? now_q : best_q.start;
	assign now_next  = (now_q == '1) ? now_q : now_q + TIME_W'(1);
	assign turn_d    = (now_next >= best_q.arrival) ? now_next - best_q.arrival : '0;
	assign burst_ext = TIME_W'(best_q.burst);

	always_comb begin
		we    = 1'b0;
		waddr = load_addr;
		wdata = '{arrival: arrival, burst: burst, prio: prio, remaining: burst,
			start: '0};
		if (load_ok) begin
			we = 1'b1;
		end else if (state_q == ST_WB && found_q) begin
			we    = 1'b1;
			waddr = best_idx_q;
			wdata = best_q;
			wdata.remaining = rem_new;
			wdata.start     = start_new;
		end
	end

	psched_ram #(
		.DEPTH(MAX_TASKS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (state_q == ST_SCAN),
		.raddr(idx_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			pend_q   <= '0;
			cnt_q    <= '0;
			now_q    <= '0;
			found_q  <= 1'b0;
			fin_q    <= 1'b0;
			done     <= 1'b0;
		end else begin
			done     <= 1'b0;
			valid_s1 <= (state_q == ST_SCAN);
			if (cand && better) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (load_ok) begin
						pend_q[load_addr] <= (burst != '0);
						cnt_q <= cnt_q + CW'(burst != '0) - CW'(pend_q[load_addr]);
					end else if (accept && action) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + AW'(1);
					if (idx_q == LAST_IDX) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					now_q   <= now_next;
					fin_q   <= found_q && (rem_new == '0);
					if (found_q && rem_new == '0) begin
						pend_q[best_idx_q] <= 1'b0;
						cnt_q <= cnt_q - CW'(1);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= idx_q;
		pend_s1 <= pend_q[idx_q];
		if (cand && better) begin
			best_idx_q <= idx_s1;
			best_q     <= rdata;
		end
		if (state_q == ST_WB) begin
			best_q.start <= start_new;
			turn_q       <= turn_d;
		end
		if (state_q == ST_OUT) begin
			ran_slot        <= found_q ? SLOT_W'(best_idx_q) : '0;
			idle            <= !found_q;
			finished        <= fin_q;
			response_time   <= fin_q ? best_q.start : '0;
			completion_time <= fin_q ? now_q : '0;
			turnaround_time <= fin_q ? turn_q : '0;
			waiting_time    <= (fin_q && turn_q >= burst_ext) ? turn_q - burst_ext : '0;
			all_done        <= (cnt_q == '0);
		end
	end
endmodule
`default_nettype wire

[verif/preemptive_priority_scheduler_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for preemptive_priority_scheduler: directed and random load and tick
// transactions, an in-bench scheduler model that predicts every tick result, and a checker.
// Depends on psched_pkg and the scheduler RTL.
module preemptive_priority_scheduler_test;
	import psched_pkg::*;

	localparam int NSLOT      = MAX_TASKS_DEF;
	localparam bit CMD_LOAD   = 1'b0;
	localparam bit CMD_TICK   = 1'b1;
	localparam int TIME_MAX   = (1 << TIME_W) - 1;
	localparam int BURST_MAX  = (1 << BURST_W) - 1;
	localparam int PRIO_MAX   = (1 << PRIO_W) - 1;
	localparam int RAND_ITEMS = 1400;

	typedef struct {
		bit                 act;
		logic [SLOT_W-1:0]  slot;
		logic [TIME_W-1:0]  arrival;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
		int                 idle_pct;
	} sched_cmd_t;

	typedef struct {
		logic [SLOT_W-1:0] ran_slot;
		bit                idle;
		bit                finished;
		logic [TIME_W-1:0] response;
		logic [TIME_W-1:0] completion;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		bit                all_done;
	} tick_outcome_t;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               start   = 1'b0;
	logic               action  = CMD_LOAD;
	logic [SLOT_W-1:0]  slot    = '0;
	logic [TIME_W-1:0]  arrival = '0;
	logic [BURST_W-1:0] burst   = '0;
	logic [PRIO_W-1:0]  prio    = '0;
	logic               busy;
	logic               done;
	logic [SLOT_W-1:0]  ran_slot;
	logic               idle;
	logic               finished;
	logic [TIME_W-1:0]  response_time;
	logic [TIME_W-1:0]  completion_time;
	logic [TIME_W-1:0]  turnaround_time;
	logic [TIME_W-1:0]  waiting_time;
	logic               all_done;

	sched_cmd_t    cmd_q[$];
	sched_cmd_t    on_port;
	tick_outcome_t outcome_q[$];
	int            errors  = 0;
	int            gen_now = 0;

	bit [TIME_W-1:0]  task_arr   [NSLOT];
	bit [BURST_W-1:0] task_len   [NSLOT];
	bit [BURST_W-1:0] task_left  [NSLOT];
	bit [PRIO_W-1:0]  task_pri   [NSLOT];
	bit [TIME_W-1:0]  task_first [NSLOT];
	bit [TIME_W-1:0]  sched_now = '0;

	preemptive_priority_scheduler #(.MAX_TASKS(NSLOT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.slot(slot),
		.arrival(arrival),
		.burst(burst),
		.prio(prio),
		.done(done),
		.ran_slot(ran_slot),
		.idle(idle),
		.finished(finished),
		.response_time(response_time),
		.completion_time(completion_time),
		.turnaround_time(turnaround_time),
		.waiting_time(waiting_time),
		.all_done(all_done)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void apply_command(input sched_cmd_t c);
		tick_outcome_t    o;
		int               pick;
		int               i;
		bit [TIME_W-1:0]  turn;
		if (c.act == CMD_LOAD) begin
			if (c.slot < NSLOT) begin
				task_arr[c.slot]  = c.arrival;
				task_len[c.slot]  = c.burst;
				task_pri[c.slot]  = c.prio;
				task_left[c.slot] = c.burst;
			end
			return;
		end
		pick = -1;
		for (i = 0; i < NSLOT; i++) begin
			if (task_left[i] != 0 && task_arr[i] <= sched_now) begin
				if (pick < 0 || task_pri[i] < task_pri[pick] ||
						(task_pri[i] == task_pri[pick] && task_arr[i] < task_arr[pick]))
					pick = i;
			end
		end
		if (pick >= 0) begin
			if (task_left[pick] == task_len[pick])
				task_first[pick] = sched_now;
			task_left[pick] = task_left[pick] - 1'b1;
		end
		if (sched_now != TIME_MAX)
			sched_now = sched_now + 1'b1;
		o.ran_slot   = pick >= 0 ? pick[SLOT_W-1:0] : '0;
		o.idle       = pick < 0;
		o.finished   = 1'b0;
		o.response   = '0;
		o.completion = '0;
		o.turnaround = '0;
		o.waiting    = '0;
		if (pick >= 0 && task_left[pick] == 0) begin
			turn         = sched_now >= task_arr[pick] ? sched_now - task_arr[pick] : '0;
			o.finished   = 1'b1;
			o.response   = task_first[pick];
			o.completion = sched_now;
			o.turnaround = turn;
			o.waiting    = turn >= task_len[pick] ? turn - task_len[pick] : '0;
		end
		o.all_done = 1'b1;
		for (i = 0; i < NSLOT; i++)
			if (task_left[i] != 0)
				o.all_done = 1'b0;
		outcome_q.push_back(o);
	endfunction

	function automatic void queue_load(input int s, input int a, input int b, input int p,
			input int pct);
		sched_cmd_t c;
		c.act      = CMD_LOAD;
		c.slot     = s[SLOT_W-1:0];
		c.arrival  = a[TIME_W-1:0];
		c.burst    = b[BURST_W-1:0];
		c.prio     = p[PRIO_W-1:0];
		c.idle_pct = pct;
		cmd_q.push_back(c);
	endfunction

	function automatic void queue_tick(input int pct);
		sched_cmd_t c;
		c.act      = CMD_TICK;
		c.slot     = SLOT_W'($urandom);
		c.arrival  = TIME_W'($urandom);
		c.burst    = BURST_W'($urandom);
		c.prio     = PRIO_W'($urandom);
		c.idle_pct = pct;
		cmd_q.push_back(c);
		if (gen_now < TIME_MAX)
			gen_now++;
	endfunction

	function automatic void check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				apply_command(on_port);
			if (!start || !busy) begin
				if (cmd_q.size() != 0 && $urandom_range(99) >= cmd_q[0].idle_pct) begin
					on_port = cmd_q.pop_front();
					start   <= 1'b1;
					action  <= on_port.act;
					slot    <= on_port.slot;
					arrival <= on_port.arrival;
					burst   <= on_port.burst;
					prio    <= on_port.prio;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		tick_outcome_t e;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				errors++;
				$display("%t unexpected result: expected none, actual ran_slot %0d idle %0d",
					$time, ran_slot, idle);
			end else begin
				e = outcome_q.pop_front();
				check_field("ran_slot", e.ran_slot, ran_slot);
				check_field("idle", e.idle, idle);
				check_field("finished", e.finished, finished);
				check_field("response_time", e.response, response_time);
				check_field("completion_time", e.completion, completion_time);
				check_field("turnaround_time", e.turnaround, turnaround_time);
				check_field("waiting_time", e.waiting, waiting_time);
				check_field("all_done", e.all_done, all_done);
			end
		end
	end

	initial begin
		#1_000_000;
		$display("preemptive_priority_scheduler test failed");
		$finish;
	end

	initial begin
		int n;
		int pct;
		int r;
		int a;
		int b;
		int p;

		queue_tick(17);
		queue_load(0, 0, 0, 0, 17);
		queue_tick(17);
		queue_load(15, 2, 1, PRIO_MAX, 17);
		queue_load(4, 2, 2, 7, 17);
		queue_load(9, 1, 1, 7, 17);
		queue_load(6, 1, 1, 7, 17);
		queue_load(1, TIME_MAX, BURST_MAX, 0, 17);
		queue_tick(17);
		queue_tick(17);
		queue_tick(17);
		queue_load(4, 3, 2, 7, 17);
		queue_tick(17);
		queue_tick(17);
		queue_tick(17);
		queue_load(1, 0, 0, PRIO_MAX, 17);
		queue_tick(17);
		queue_load(2, gen_now + 2, 3, 200, 17);
		queue_load(3, gen_now + 3, 1, 1, 17);
		repeat (6) queue_tick(17);

		for (n = 0; n < RAND_ITEMS; n++) begin
			pct = n < RAND_ITEMS / 3 ? 17 : (n < 2 * RAND_ITEMS / 3 ? 85 : 0);
			if ($urandom_range(99) < 45) begin
				r = $urandom_range(99);
				if (r < 10)
					b = 0;
				else if (r < 90)
					b = $urandom_range(12, 1);
				else
					b = $urandom_range(BURST_MAX);
				if (b > 12)
					p = $urandom_range(PRIO_MAX, PRIO_MAX - 15);
				else if ($urandom_range(99) < 60)
					p = $urandom_range(3);
				else
					p = $urandom_range(PRIO_MAX);
				if ($urandom_range(99) < 90)
					a = gen_now + int'($urandom_range(12)) - 4;
				else
					a = $urandom_range(TIME_MAX);
				if (a < 0)
					a = 0;
				queue_load($urandom_range(NSLOT - 1), a, b, p, pct);
			end else begin
				queue_tick(pct);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || start || busy || outcome_q.size() != 0)
			@(negedge clk);
		repeat (NSLOT + 8) @(posedge clk);
		if (errors == 0)
			$display("preemptive_priority_scheduler test passed");
		else
			$display("preemptive_priority_scheduler test failed");
		$finish;
	end
endmodule
